// ===== hw/rtl/soi_pkg.sv =====
package soi_pkg;

  localparam int MAX_BEAMS = 1024;
  localparam int ADDR_W    = $clog2(MAX_BEAMS);
  localparam int CNT_W     = ADDR_W + 1;

  localparam logic [16:0] HALF_PI   = 17'd102944;
  localparam logic [33:0] CORDIC_K  = 34'd652032874;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [15:0] RANGE_MAX = 16'hFFFF;

  // configuration register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_STEP   = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic        op;
    logic [9:0]  beam_index;
    logic [15:0] range_mm;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  query_index;
    logic [15:0] expanded_range_mm;
  } out_item_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_QINIT,
    CMD_RD,
    CMD_RD_IDX,
    CMD_J_INC,
    CMD_J_CLR,
    CMD_BEST_INIT,
    CMD_BEAM,
    CMD_SQ,
    CMD_SQ_STEP,
    CMD_AT_INIT,
    CMD_COR_STEP,
    CMD_AT_FIN,
    CMD_COS1_INIT,
    CMD_LINE_INIT,
    CMD_DIV_STEP,
    CMD_LINE_FIN,
    CMD_ARC_MUL,
    CMD_ARC_DIV_INIT,
    CMD_COS2_INIT,
    CMD_ARC_FIN,
    CMD_SUM,
    CMD_OUT_ZERO,
    CMD_OUT_BEST
  } cmd_t;

  typedef struct packed {
    logic oor;        // query index at or beyond beam count
    logic lt_r;       // read beam closer than radius
    logic j_last;
    logic sqrt_last;
    logic need_atan;
    logic cor_last;
    logic diff_gt_a;
    logic line_div;
    logic div_last;
    logic a_zero;
  } stat_t;

  function automatic logic [15:0] atan_tab(input logic [4:0] i);
    logic [15:0] v;
    begin
      case (i)
        5'd0:    v = 16'd51472;
        5'd1:    v = 16'd30386;
        5'd2:    v = 16'd16055;
        5'd3:    v = 16'd8150;
        5'd4:    v = 16'd4091;
        5'd5:    v = 16'd2047;
        5'd6:    v = 16'd1024;
        5'd7:    v = 16'd512;
        5'd8:    v = 16'd256;
        5'd9:    v = 16'd128;
        5'd10:   v = 16'd64;
        5'd11:   v = 16'd32;
        5'd12:   v = 16'd16;
        5'd13:   v = 16'd8;
        5'd14:   v = 16'd4;
        5'd15:   v = 16'd2;
        5'd16:   v = 16'd1;
        default: v = 16'd0;
      endcase
      atan_tab = v;
    end
  endfunction

endpackage

// ===== hw/rtl/soi_ctrl.sv =====
module soi_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            op,
  input  soi_pkg::stat_t  st,
  output soi_pkg::cmd_t   cmd,
  output logic            busy
);
  import soi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_Q0, S_P1_RD, S_P1_CK, S_P2_RDI, S_P2_BI, S_P2_RD, S_P2_LD,
    S_P2_SQ, S_P2_SQI, S_P2_AT0, S_P2_ATI, S_P2_ATF, S_P2_CMP, S_P2_C1I,
    S_P2_LN, S_P2_LDV, S_P2_LF, S_P2_AR0, S_P2_AD0, S_P2_ADV, S_P2_C2,
    S_P2_C2I, S_P2_AM, S_P2_SUM, S_P2_NEXT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (op == OP_QUERY) begin
            cmd       = CMD_QINIT;
            state_nxt = S_Q0;
          end else begin
            cmd = CMD_LOAD;
          end
        end
      end
      S_Q0: begin
        if (st.oor) begin
          cmd       = CMD_OUT_ZERO;
          state_nxt = S_IDLE;
        end else begin
          cmd       = CMD_RD;
          state_nxt = S_P1_CK;
        end
      end
      S_P1_RD: begin
        cmd       = CMD_RD;
        state_nxt = S_P1_CK;
      end
      S_P1_CK: begin
        if (st.lt_r) begin
          cmd       = CMD_OUT_ZERO;
          state_nxt = S_IDLE;
        end else if (st.j_last) begin
          cmd       = CMD_J_CLR;
          state_nxt = S_P2_RDI;
        end else begin
          cmd       = CMD_J_INC;
          state_nxt = S_P1_RD;
        end
      end
      S_P2_RDI: begin
        cmd       = CMD_RD_IDX;
        state_nxt = S_P2_BI;
      end
      S_P2_BI: begin
        cmd       = CMD_BEST_INIT;
        state_nxt = S_P2_RD;
      end
      S_P2_RD: begin
        cmd       = CMD_RD;
        state_nxt = S_P2_LD;
      end
      S_P2_LD: begin
        cmd       = CMD_BEAM;
        state_nxt = S_P2_SQ;
      end
      S_P2_SQ: begin
        cmd       = CMD_SQ;
        state_nxt = S_P2_SQI;
      end
      S_P2_SQI: begin
        cmd = CMD_SQ_STEP;
        if (st.sqrt_last) state_nxt = S_P2_AT0;
      end
      S_P2_AT0: begin
        cmd       = CMD_AT_INIT;
        state_nxt = st.need_atan ? S_P2_ATI : S_P2_CMP;
      end
      S_P2_ATI: begin
        cmd = CMD_COR_STEP;
        if (st.cor_last) state_nxt = S_P2_ATF;
      end
      S_P2_ATF: begin
        cmd       = CMD_AT_FIN;
        state_nxt = S_P2_CMP;
      end
      S_P2_CMP: begin
        if (st.diff_gt_a) begin
          state_nxt = S_P2_NEXT;
        end else begin
          cmd       = CMD_COS1_INIT;
          state_nxt = S_P2_C1I;
        end
      end
      S_P2_C1I: begin
        cmd = CMD_COR_STEP;
        if (st.cor_last) state_nxt = S_P2_LN;
      end
      S_P2_LN: begin
        cmd       = CMD_LINE_INIT;
        state_nxt = st.line_div ? S_P2_LDV : S_P2_AR0;
      end
      S_P2_LDV: begin
        cmd = CMD_DIV_STEP;
        if (st.div_last) state_nxt = S_P2_LF;
      end
      S_P2_LF: begin
        cmd       = CMD_LINE_FIN;
        state_nxt = S_P2_AR0;
      end
      S_P2_AR0: begin
        cmd       = CMD_ARC_MUL;
        state_nxt = st.a_zero ? S_P2_SUM : S_P2_AD0;
      end
      S_P2_AD0: begin
        cmd       = CMD_ARC_DIV_INIT;
        state_nxt = S_P2_ADV;
      end
      S_P2_ADV: begin
        cmd = CMD_DIV_STEP;
        if (st.div_last) state_nxt = S_P2_C2;
      end
      S_P2_C2: begin
        cmd       = CMD_COS2_INIT;
        state_nxt = S_P2_C2I;
      end
      S_P2_C2I: begin
        cmd = CMD_COR_STEP;
        if (st.cor_last) state_nxt = S_P2_AM;
      end
      S_P2_AM: begin
        cmd       = CMD_ARC_FIN;
        state_nxt = S_P2_SUM;
      end
      S_P2_SUM: begin
        cmd       = CMD_SUM;
        state_nxt = S_P2_NEXT;
      end
      S_P2_NEXT: begin
        if (st.j_last) begin
          cmd       = CMD_OUT_BEST;
          state_nxt = S_IDLE;
        end else begin
          cmd       = CMD_J_INC;
          state_nxt = S_P2_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/soi_dp.sv =====
module soi_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  soi_pkg::cmd_t       cmd,
  input  soi_pkg::in_item_t   in_data,
  input  logic [15:0]         radius,
  input  logic [15:0]         step,
  input  logic [10:0]         beam_count,
  output soi_pkg::stat_t      st,
  output logic                out_valid,
  output soi_pkg::out_item_t  out_data
);
  import soi_pkg::*;

  logic [15:0] mem [MAX_BEAMS];
  logic [15:0] rd_q;

  logic [ADDR_W-1:0] idx_r, j_r;
  logic [15:0]       best_r, d_r, line_r, arc_r;
  logic [31:0]       rr_r, v_r, res_r, bit_r;
  logic [3:0]        sq_cnt_r;
  logic [25:0]       diff_r;
  logic [16:0]       a_r;
  logic signed [33:0] x_r, y_r;
  logic signed [19:0] z_r;
  logic               vec_r;
  logic [4:0]         cor_i_r;
  logic [32:0]        rem_r;
  logic [30:0]        dvs_r;
  logic [16:0]        low_r, q_r;
  logic [4:0]         div_cnt_r, div_n_r;
  logic [33:0]        prod_r;
  logic               out_valid_r;
  out_item_t          out_r;

  function automatic logic signed [33:0] sshr(input logic signed [33:0] v,
                                              input logic [4:0] s);
    logic [33:0] m;
    begin
      m    = v[33] ? 34'(-v) : 34'(v);
      m    = m >> s;
      sshr = v[33] ? -$signed(m) : $signed(m);
    end
  endfunction

  // ---- combinational helpers
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] beam_gap;
  logic [31:0]       sq_trial;
  logic [15:0]       h, dr;
  logic signed [33:0] sx, sy;
  logic               dir_a;
  logic signed [19:0] tab;
  logic               cd_pos, line_sat;
  logic [32:0]        div_t;
  logic [30:0]        c_cl, om;
  logic [46:0]        arc_prod;
  logic [16:0]        sum;
  logic [15:0]        cand;

  always_comb begin
    count    = (beam_count > CNT_W'(MAX_BEAMS)) ? CNT_W'(MAX_BEAMS) : beam_count;
    beam_gap = (idx_r > j_r) ? (idx_r - j_r) : (j_r - idx_r);
    sq_trial = res_r + bit_r;
    h        = res_r[15:0];
    dr       = d_r - radius;
    sx       = sshr(x_r, cor_i_r);
    sy       = sshr(y_r, cor_i_r);
    dir_a    = vec_r ? (y_r > 0) : z_r[19];
    tab      = $signed({4'b0, atan_tab(cor_i_r)});
    cd_pos   = !x_r[33] && (x_r != 34'sd0);
    line_sat = ({4'b0, dr, 14'b0} >= $unsigned(x_r));
    div_t    = {rem_r[31:0], low_r[16]};
    if (x_r[33])                        c_cl = 31'd0;
    else if ($unsigned(x_r) > {3'b0, ONE_Q30}) c_cl = ONE_Q30;
    else                                c_cl = x_r[30:0];
    om       = ONE_Q30 - c_cl;
    arc_prod = 47'(radius) * 47'(om);
    sum      = {1'b0, line_r} + {1'b0, arc_r};
    cand     = sum[16] ? RANGE_MAX : sum[15:0];
  end

  always_comb begin
    st.oor       = ({1'b0, idx_r} >= count);
    st.lt_r      = (rd_q < radius);
    st.j_last    = ({1'b0, j_r} == (count - CNT_W'(1)));
    st.sqrt_last = (sq_cnt_r == 4'd15);
    st.need_atan = (radius != 16'd0) && (h != 16'd0);
    st.cor_last  = (cor_i_r == 5'd16);
    st.diff_gt_a = (diff_r > {9'b0, a_r});
    st.line_div  = cd_pos && !line_sat;
    st.div_last  = (div_cnt_r == div_n_r);
    st.a_zero    = (a_r == 17'd0);
  end

  // beam store
  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD) mem[in_data.beam_index] <= in_data.range_mm;
    if (cmd == CMD_RD)          rd_q <= mem[j_r];
    else if (cmd == CMD_RD_IDX) rd_q <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= (cmd == CMD_OUT_ZERO) || (cmd == CMD_OUT_BEST);
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_QINIT: begin
        idx_r <= in_data.beam_index;
        j_r   <= '0;
        rr_r  <= radius * radius;
      end
      CMD_J_INC:     j_r <= j_r + ADDR_W'(1);
      CMD_J_CLR:     j_r <= '0;
      CMD_BEST_INIT: best_r <= rd_q;
      CMD_BEAM: begin
        d_r    <= rd_q;
        diff_r <= 26'(beam_gap) * 26'(step);
      end
      CMD_SQ: begin
        v_r      <= (d_r * d_r) - rr_r;
        res_r    <= '0;
        bit_r    <= 32'h4000_0000;
        sq_cnt_r <= '0;
      end
      CMD_SQ_STEP: begin
        if (v_r >= sq_trial) begin
          v_r   <= v_r - sq_trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r    <= bit_r >> 2;
        sq_cnt_r <= sq_cnt_r + 4'd1;
      end
      CMD_AT_INIT: begin
        if (radius == 16'd0)  a_r <= '0;
        else if (h == 16'd0)  a_r <= HALF_PI;
        x_r     <= $signed({4'b0, h, 14'b0});
        y_r     <= $signed({4'b0, radius, 14'b0});
        z_r     <= '0;
        vec_r   <= 1'b1;
        cor_i_r <= '0;
      end
      CMD_COR_STEP: begin
        if (dir_a) begin
          x_r <= x_r + sy;
          y_r <= y_r - sx;
          z_r <= z_r + tab;
        end else begin
          x_r <= x_r - sy;
          y_r <= y_r + sx;
          z_r <= z_r - tab;
        end
        cor_i_r <= cor_i_r + 5'd1;
      end
      CMD_AT_FIN: begin
        if (z_r[19])                          a_r <= '0;
        else if (z_r > $signed({3'b0, HALF_PI})) a_r <= HALF_PI;
        else                                  a_r <= z_r[16:0];
      end
      CMD_COS1_INIT: begin
        x_r     <= $signed(CORDIC_K);
        y_r     <= '0;
        z_r     <= $signed(diff_r[19:0]);
        vec_r   <= 1'b0;
        cor_i_r <= '0;
      end
      CMD_LINE_INIT: begin
        if (!cd_pos)       line_r <= (d_r == radius) ? 16'd0 : RANGE_MAX;
        else if (line_sat) line_r <= RANGE_MAX;
        rem_r     <= {3'b0, dr, 14'b0};
        dvs_r     <= x_r[30:0];
        low_r     <= '0;
        q_r       <= '0;
        div_cnt_r <= '0;
        div_n_r   <= 5'd15;
      end
      CMD_DIV_STEP: begin
        if (div_t >= {2'b0, dvs_r}) begin
          rem_r <= div_t - {2'b0, dvs_r};
          q_r   <= {q_r[15:0], 1'b1};
        end else begin
          rem_r <= div_t;
          q_r   <= {q_r[15:0], 1'b0};
        end
        low_r     <= {low_r[15:0], 1'b0};
        div_cnt_r <= div_cnt_r + 5'd1;
      end
      CMD_LINE_FIN: line_r <= q_r[15:0];
      CMD_ARC_MUL: begin
        prod_r <= 34'(HALF_PI - a_r) * 34'(diff_r[16:0]);
        arc_r  <= '0;
      end
      CMD_ARC_DIV_INIT: begin
        rem_r     <= {16'b0, prod_r[33:17]};
        low_r     <= prod_r[16:0];
        dvs_r     <= {14'b0, a_r};
        q_r       <= '0;
        div_cnt_r <= '0;
        div_n_r   <= 5'd16;
      end
      CMD_COS2_INIT: begin
        x_r     <= $signed(CORDIC_K);
        y_r     <= '0;
        z_r     <= $signed({3'b0, q_r});
        vec_r   <= 1'b0;
        cor_i_r <= '0;
      end
      CMD_ARC_FIN: arc_r <= arc_prod[45:30];
      CMD_SUM: if (cand < best_r) best_r <= cand;
      CMD_OUT_ZERO: begin
        out_r.query_index       <= idx_r;
        out_r.expanded_range_mm <= 16'd0;
      end
      CMD_OUT_BEST: begin
        out_r.query_index       <= idx_r;
        out_r.expanded_range_mm <= best_r;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/scan_obstacle_inflation_top.sv =====
// Scan obstacle inflation: grows a range scan by the robot radius.
//
// Input: start with in_data (op, beam_index, range_mm). A transaction is
// taken when start is high and busy is low. A load (op 0) writes one range
// sample into the 1024-entry beam store; busy stays low and no result
// follows. A query (op 1) raises busy until its answer is out.
// Result: out_valid is high for exactly one cycle with out_data
// (query_index, expanded_range_mm); the receiver cannot stall, so it must
// take the result in that cycle.
// Configuration: cfg_we/cfg_addr/cfg_wdata, to be written by the user only
// while idle; the block does not enforce it. 0 robot radius, 1 angle step,
// 2 beam count. Other indexes are ignored. Query, N the effective beam count:
// a first sweep reads every beam (it stops early on a beam inside the radius),
// then a second sweep finds each beam's half-angle and skips the line and arc
// terms for a beam outside it. The shared CORDIC unit (17 steps per angle),
// the 16-step square root and the bit-serial divider do that work.
// A query index at or beyond N answers zero.
// Reset (synchronous, rst_n low) restores the register defaults and idles
// the sequencer; the beam store is not cleared and must be loaded first.
module scan_obstacle_inflation_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  soi_pkg::in_item_t  in_data,
  output logic               out_valid,
  output soi_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata
);
  import soi_pkg::*;

  logic [15:0] radius_r, step_r;
  logic [10:0] count_r;
  cmd_t        cmd;
  stat_t       st;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 16'd1500;
      step_r   <= 16'd1144;
      count_r  <= 11'd1024;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RADIUS: radius_r <= cfg_wdata;
        REG_STEP:   step_r   <= cfg_wdata;
        REG_COUNT:  count_r  <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // sequencer: walks both sweeps and steps the shared arithmetic
  soi_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_data.op),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  // beam store, square root, CORDIC, divider and the running minimum
  soi_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_data    (in_data),
    .radius     (radius_r),
    .step       (step_r),
    .beam_count (count_r),
    .st         (st),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule
